>>> rtl/sha_pkg.sv
package sha_pkg;

    localparam int unsigned WordW  = 64;
    localparam int unsigned CntW   = 4;
    localparam int unsigned Rounds = 80;
    localparam int unsigned RndW   = 7;
    localparam int unsigned QDepth = 4;
    localparam int unsigned QPtrW  = 2;

    typedef logic [WordW-1:0] t_word;

    typedef enum logic [1:0] {
        CMD_DATA = 2'd0,
        CMD_PAD  = 2'd1,
        CMD_LEN  = 2'd2
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind kind;
        t_word     word;
    } t_cmd;

    localparam t_word IV [8] = '{
        64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b,
        64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
        64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
        64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
    };

    localparam t_word KTAB [80] = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
        64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
        64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
        64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
        64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
        64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
        64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
        64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
        64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
        64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
        64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
        64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
        64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
        64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
    };

    function automatic t_word rotr(input t_word x, input int unsigned n);
        rotr = (x >> n) | (x << (WordW - n));
    endfunction

endpackage

>>> rtl/sha_if.sv
interface sha_in_if;
    import sha_pkg::*;
    logic            valid;
    logic            ready;
    logic [63:0]     data_word;
    logic [3:0]      byte_count;
    logic            last_word;
    modport source (output valid, data_word, byte_count, last_word, input ready);
    modport sink   (input valid, data_word, byte_count, last_word, output ready);
endinterface

interface sha_out_if;
    logic            valid;
    logic            ready;
    logic [63:0]     digest_word;
    logic            last_digest;
    modport source (output valid, digest_word, last_digest, input ready);
    modport sink   (input valid, digest_word, last_digest, output ready);
endinterface

>>> rtl/sha_front.sv
module sha_front
    import sha_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    sha_in_if.sink      in_ch,
    output logic        o_cmd_valid,
    output t_cmd        o_cmd,
    input  logic        i_cmd_ready
);

    typedef enum logic [1:0] {
        S_TAKE,
        S_EIGHT,
        S_LEN
    } t_state;

    t_state      r_state;
    t_word       r_len;
    t_word       n_len;
    logic [3:0]  cnt;
    t_word       keep;
    t_word       padded;
    logic        take;

    always_comb begin
        cnt = (in_ch.byte_count > 4'd8) ? 4'd8 : in_ch.byte_count;
        keep = (cnt == 4'd0) ? '0 : ~(t_word'(0)) << (7'd64 - {cnt, 3'b000});
        padded = (in_ch.data_word & keep) | (t_word'(8'h80) << (7'd56 - {cnt, 3'b000}));
        if (!in_ch.last_word) begin
            n_len = r_len + t_word'(64);
        end else begin
            n_len = r_len + t_word'({cnt, 3'b000});
        end
    end

    assign in_ch.ready = (r_state == S_TAKE) && i_cmd_ready;
    assign take = in_ch.valid && in_ch.ready;

    always_comb begin
        o_cmd_valid = 1'b0;
        o_cmd.kind = CMD_DATA;
        o_cmd.word = in_ch.data_word;
        case (r_state)
            S_TAKE: begin
                o_cmd_valid = in_ch.valid;
                if (in_ch.last_word && cnt != 4'd8) begin
                    o_cmd.kind = CMD_PAD;
                    o_cmd.word = padded;
                end
            end
            S_EIGHT: begin
                o_cmd_valid = 1'b1;
                o_cmd.kind = CMD_PAD;
                o_cmd.word = 64'h8000000000000000;
            end
            S_LEN: begin
                o_cmd_valid = 1'b1;
                o_cmd.kind = CMD_LEN;
                o_cmd.word = r_len;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_TAKE;
            r_len <= '0;
        end else begin
            case (r_state)
                S_TAKE: begin
                    if (take) begin
                        r_len <= n_len;
                        if (in_ch.last_word) begin
                            r_state <= (cnt == 4'd8) ? S_EIGHT : S_LEN;
                        end
                    end
                end
                S_EIGHT: if (i_cmd_ready) r_state <= S_LEN;
                S_LEN: begin
                    if (i_cmd_ready) begin
                        r_state <= S_TAKE;
                        r_len <= '0;
                    end
                end
                default: r_state <= S_TAKE;
            endcase
        end
    end

endmodule

>>> rtl/sha_queue.sv
module sha_queue
    import sha_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_cmd  i_cmd,
    output logic  o_ready,
    output logic  o_valid,
    output t_cmd  o_cmd,
    input  logic  i_pop
);

    t_cmd             r_mem [QDepth];
    logic [QPtrW-1:0] r_wp;
    logic [QPtrW-1:0] r_rp;
    logic [QPtrW:0]   r_cnt;
    logic             wr;
    logic             rd;

    assign o_ready = r_cnt != (QPtrW+1)'(QDepth);
    assign o_valid = r_cnt != '0;
    assign o_cmd = r_mem[r_rp];
    assign wr = i_push && o_ready;
    assign rd = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (wr) r_mem[r_wp] <= i_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) r_wp <= r_wp + 1'b1;
            if (rd) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (QPtrW+1)'(wr) - (QPtrW+1)'(rd);
        end
    end

    a_no_over: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (QPtrW+1)'(QDepth)) else $error("queue count overflow");
    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr && !rd) |=> r_cnt == $past(r_cnt) + 1'b1) else $error("queue count step");
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |-> !rd) else $error("pop from empty queue");

endmodule

>>> rtl/sha_back.sv
module sha_back
    import sha_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cmd_valid,
    input  t_cmd        i_cmd,
    output logic        o_cmd_pop,
    sha_out_if.source   out_ch
);

    typedef enum logic [2:0] {
        S_FILL,
        S_ROUND,
        S_ADD,
        S_EMIT
    } t_state;

    t_state          r_state;
    t_word           r_w [16];
    t_word           r_h [8];
    t_word           r_v [8];
    logic [3:0]      r_pos;
    logic [RndW-1:0] r_t;
    logic            r_final;
    logic            r_pad_seen;
    logic [2:0]      r_oidx;
    logic            r_ovalid;
    t_word           r_oword;
    logic            r_olast;

    t_word wt, s0, s1, ch, mj, t1, t2, x2, x15, lo0, lo1, wnew;
    logic  write_slot;
    logic  take;
    logic  len_close;
    logic  [3:0] ti;

    // the length word closes a block only at slot 15 right after padding zeros
    assign ti = r_t[3:0];
    assign take = (r_state == S_FILL) && i_cmd_valid;
    assign len_close = (r_pos == 4'd15) && r_pad_seen;
    assign write_slot = take && (i_cmd.kind != CMD_LEN || len_close);
    assign o_cmd_pop = write_slot;

    always_comb begin
        x2  = r_w[ti - 4'd2];
        x15 = r_w[ti - 4'd15];
        lo1 = rotr(x2, 19) ^ rotr(x2, 61) ^ (x2 >> 6);
        lo0 = rotr(x15, 1) ^ rotr(x15, 8) ^ (x15 >> 7);
        wnew = lo1 + r_w[ti - 4'd7] + lo0 + r_w[ti];
        wt = (r_t >= RndW'(16)) ? wnew : r_w[ti];
        s1 = rotr(r_v[4], 14) ^ rotr(r_v[4], 18) ^ rotr(r_v[4], 41);
        ch = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        t1 = r_v[7] + s1 + ch + KTAB[r_t] + wt;
        s0 = rotr(r_v[0], 28) ^ rotr(r_v[0], 34) ^ rotr(r_v[0], 39);
        mj = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t2 = s0 + mj;
    end

    assign out_ch.valid = r_ovalid;
    assign out_ch.digest_word = r_oword;
    assign out_ch.last_digest = r_olast;

    always_ff @(posedge i_clk) begin
        if (write_slot) begin
            r_w[r_pos] <= i_cmd.word;
        end else if (take) begin
            r_w[r_pos] <= '0;
        end else if (r_state == S_ROUND) begin
            r_w[ti] <= wt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_FILL;
            r_pos <= '0;
            r_t <= '0;
            r_final <= 1'b0;
            r_pad_seen <= 1'b0;
            r_oidx <= '0;
            r_ovalid <= 1'b0;
            for (int i = 0; i < 8; i++) begin
                r_h[i] <= IV[i];
                r_v[i] <= '0;
            end
        end else begin
            case (r_state)
                S_FILL: begin
                    if (take) begin
                        r_pos <= r_pos + 1'b1;
                        r_pad_seen <= (i_cmd.kind == CMD_LEN) && !len_close;
                        if (r_pos == 4'd15) begin
                            r_final <= (i_cmd.kind == CMD_LEN) && len_close;
                            r_state <= S_ROUND;
                            r_t <= '0;
                            for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
                        end
                    end
                end
                S_ROUND: begin
                    r_v[7] <= r_v[6];
                    r_v[6] <= r_v[5];
                    r_v[5] <= r_v[4];
                    r_v[4] <= r_v[3] + t1;
                    r_v[3] <= r_v[2];
                    r_v[2] <= r_v[1];
                    r_v[1] <= r_v[0];
                    r_v[0] <= t1 + t2;
                    r_t <= r_t + 1'b1;
                    if (r_t == RndW'(Rounds - 1)) r_state <= S_ADD;
                end
                S_ADD: begin
                    for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
                    if (r_final) begin
                        r_state <= S_EMIT;
                        r_oidx <= '0;
                    end else begin
                        r_state <= S_FILL;
                    end
                end
                S_EMIT: begin
                    if (!r_ovalid || out_ch.ready) begin
                        if (r_ovalid && r_olast) begin
                            r_ovalid <= 1'b0;
                            r_state <= S_FILL;
                            r_final <= 1'b0;
                            r_pad_seen <= 1'b0;
                            for (int i = 0; i < 8; i++) r_h[i] <= IV[i];
                        end else begin
                            r_ovalid <= 1'b1;
                            r_oword <= r_h[r_oidx];
                            r_olast <= (r_oidx == 3'd7);
                            r_oidx <= r_oidx + 1'b1;
                        end
                    end
                end
                default: r_state <= S_FILL;
            endcase
        end
    end

    a_len_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && i_cmd.kind == CMD_LEN && len_close) |=> r_state == S_ROUND && r_final)
        else $error("length word did not close the block");
    a_round_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROUND && r_t == RndW'(Rounds - 1)) |=> r_state == S_ADD)
        else $error("round count overrun");
    a_out_only_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> r_state == S_EMIT) else $error("digest outside emit");

endmodule

>>> rtl/sha512_hash_engine_core.sv
// SHA-512 engine.
// Input channel: 64-bit big-endian message words with a byte count and a
// last-word flag; only the final word may carry fewer than eight bytes.
// Output channel: eight 64-bit digest words, word 0 first, last_digest on
// word 7.
// The front accepts words, pads the final one and produces the length word;
// a four-entry queue feeds the back, which fills a 16-word schedule at one
// word per cycle while the queue holds words, runs 80 rounds at one round
// per cycle and adds the result into the hash state. It takes no words
// during the rounds. After the final word the padding zeros drain at one
// per cycle, then the digest follows one word a cycle while ready is high.
// Reset (synchronous, active low) loads the initial hash values and empties
// the queue. A stalled receiver holds the digest register; the back then
// stops, the queue fills and the input side deasserts ready.
module sha512_hash_engine_core
    import sha_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    sha_in_if.sink     in_ch,
    sha_out_if.source  out_ch
);

    logic f_valid, q_ready, b_valid, b_pop, pad_valid;
    t_cmd f_cmd, b_cmd, pad_cmd;

    sha_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .in_ch(in_ch),
        .o_cmd_valid(f_valid), .o_cmd(f_cmd), .i_cmd_ready(q_ready)
    );

    sha_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(f_valid), .i_cmd(f_cmd), .o_ready(q_ready),
        .o_valid(b_valid), .o_cmd(b_cmd), .i_pop(b_pop)
    );

    assign pad_valid = b_valid;
    assign pad_cmd = b_cmd;

    sha_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd_valid(pad_valid), .i_cmd(pad_cmd), .o_cmd_pop(b_pop),
        .out_ch(out_ch)
    );

endmodule
